/* rtl/core/lmfe_pkg.sv */
// shared types and constants for the led matrix framebuffer engine
// command codes, queue entry and result structs; no dependencies
`default_nettype none

package lmfe_pkg;

  localparam int LMFE_COLS        = 16;
  localparam int LMFE_ROWS        = 16;
  localparam int LMFE_COORD_W     = 4;
  localparam int LMFE_PHASE_W     = 3;
  localparam int LMFE_TICK_W      = 16;
  localparam int LMFE_CMD_W       = 4;
  localparam int LMFE_IN_TDATA_W  = 24;
  localparam int LMFE_OUT_TDATA_W = 56;
  localparam int LMFE_QUEUE_DEPTH = 2;

  localparam logic [LMFE_CMD_W-1:0] CMD_PLOT  = 4'd0;
  localparam logic [LMFE_CMD_W-1:0] CMD_READ  = 4'd1;
  localparam logic [LMFE_CMD_W-1:0] CMD_CLEAR = 4'd2;
  localparam logic [LMFE_CMD_W-1:0] CMD_FILL  = 4'd3;
  localparam logic [LMFE_CMD_W-1:0] CMD_LEFT  = 4'd4;
  localparam logic [LMFE_CMD_W-1:0] CMD_RIGHT = 4'd5;
  localparam logic [LMFE_CMD_W-1:0] CMD_UP    = 4'd6;
  localparam logic [LMFE_CMD_W-1:0] CMD_DOWN  = 4'd7;
  localparam logic [LMFE_CMD_W-1:0] CMD_LINE  = 4'd8;
  localparam logic [LMFE_CMD_W-1:0] CMD_FLIP  = 4'd9;
  localparam logic [LMFE_CMD_W-1:0] CMD_TICK  = 4'd10;

  typedef logic [LMFE_COLS-1:0]    row_t;
  typedef logic [LMFE_COORD_W-1:0] coord_t;

  // decoded command with the bresenham setup already worked out
  typedef struct packed {
    logic [LMFE_CMD_W-1:0] op;
    coord_t                x_first;
    coord_t                y_first;
    logic                  color;
    logic                  x_major;
    logic                  x_neg;
    logic                  y_neg;
    coord_t                den;
    coord_t                add;
    coord_t                acc0;
  } lmfe_cmd_t;

  typedef struct packed {
    logic [LMFE_TICK_W-1:0]  tick_count;
    logic [31:0]             anode_bits;
    logic [LMFE_PHASE_W-1:0] scan_row;
    logic                    pixel_on;
  } lmfe_res_t;

endpackage

`default_nettype wire

/* rtl/core/lmfe_front.sv */
// front end: registers incoming words and decodes them into queue entries
// works out line deltas, directions and major axis; uses lmfe_pkg
`default_nettype none

module lmfe_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [lmfe_pkg::LMFE_IN_TDATA_W-1:0]  in_tdata,
  output logic                                       push_valid,
  input  wire logic                                  push_ready,
  output lmfe_pkg::lmfe_cmd_t                        push_cmd
);
  import lmfe_pkg::*;

  logic      fv_r, fv_nxt;
  lmfe_cmd_t fcmd_r, fcmd_nxt;
  lmfe_cmd_t dec;
  coord_t    xa, ya, xb, yb, dx, dy;
  logic      in_acc;

  always_comb begin
    xa = in_tdata[7:4];
    ya = in_tdata[11:8];
    xb = in_tdata[15:12];
    yb = in_tdata[19:16];
    dx = (xb >= xa) ? (xb - xa) : (xa - xb);
    dy = (yb >= ya) ? (yb - ya) : (ya - yb);
    dec.op      = in_tdata[3:0];
    dec.x_first = xa;
    dec.y_first = ya;
    dec.color   = in_tdata[20];
    dec.x_neg   = (xb < xa);
    dec.y_neg   = (yb < ya);
    dec.x_major = (dx >= dy);
    dec.den     = dec.x_major ? dx : dy;
    dec.add     = dec.x_major ? dy : dx;
    dec.acc0    = dec.den >> 1;
  end

  assign in_tready  = !fv_r || push_ready;
  assign in_acc     = in_tvalid && in_tready;
  assign push_valid = fv_r;
  assign push_cmd   = fcmd_r;

  always_comb begin
    fv_nxt   = fv_r;
    fcmd_nxt = fcmd_r;
    if (in_acc) begin
      fv_nxt   = 1'b1;
      fcmd_nxt = dec;
    end else if (push_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    fcmd_r <= fcmd_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/lmfe_queue.sv */
// short command queue between front end and execution back end
// register-based, fall-through read; uses lmfe_pkg for the entry type
`default_nettype none

module lmfe_queue #(
  parameter int DEPTH = lmfe_pkg::LMFE_QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  input  wire lmfe_pkg::lmfe_cmd_t wr_cmd,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output lmfe_pkg::lmfe_cmd_t      rd_cmd
);
  import lmfe_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lmfe_cmd_t        ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = ent_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      ent_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lmfe_back.sv */
// back end: drawing and refresh buffers, line walker, scan counter, result register
// executes queue entries one at a time; uses lmfe_pkg
`default_nettype none

module lmfe_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire lmfe_pkg::lmfe_cmd_t q_cmd,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output lmfe_pkg::lmfe_res_t      out_res
);
  import lmfe_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LINE = 1'b1;

  logic                    state_r, state_nxt;
  row_t                    draw_r [LMFE_ROWS];
  row_t                    draw_nxt [LMFE_ROWS];
  row_t                    shown_r [LMFE_ROWS];
  row_t                    shown_nxt [LMFE_ROWS];
  logic [LMFE_PHASE_W-1:0] phase_r, phase_nxt;
  logic [LMFE_TICK_W-1:0]  tick_r, tick_nxt;
  coord_t                  lx_r, lx_nxt, ly_r, ly_nxt;
  coord_t                  acc_r, acc_nxt, den_r, den_nxt, add_r, add_nxt;
  coord_t                  cnt_r, cnt_nxt;
  logic                    xmaj_r, xmaj_nxt, xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic                    color_r, color_nxt;
  logic                    out_valid_r, out_valid_nxt;
  lmfe_res_t               out_res_r, out_res_nxt;
  lmfe_res_t               res;
  logic                    out_free, load_out, carry, x_step, y_step;
  logic [LMFE_COORD_W:0]   sum;

  assign out_free   = !out_valid_r || out_tready;
  assign q_ready    = (state_r == ST_IDLE) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

  always_comb begin
    state_nxt = state_r;
    draw_nxt  = draw_r;
    shown_nxt = shown_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    lx_nxt    = lx_r;
    ly_nxt    = ly_r;
    acc_nxt   = acc_r;
    den_nxt   = den_r;
    add_nxt   = add_r;
    cnt_nxt   = cnt_r;
    xmaj_nxt  = xmaj_r;
    xneg_nxt  = xneg_r;
    yneg_nxt  = yneg_r;
    color_nxt = color_r;
    load_out  = 1'b0;
    res       = '0;
    res.tick_count = tick_r;
    sum    = {1'b0, acc_r} + {1'b0, add_r};
    carry  = (sum >= {1'b0, den_r});
    x_step = xmaj_r ? 1'b1 : carry;
    y_step = xmaj_r ? carry : 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          load_out = 1'b1;
          case (q_cmd.op)
            CMD_PLOT: begin
              draw_nxt[q_cmd.y_first][q_cmd.x_first] = q_cmd.color;
            end
            CMD_READ: begin
              res.pixel_on = draw_r[q_cmd.y_first][q_cmd.x_first];
            end
            CMD_CLEAR: begin
              for (int i = 0; i < LMFE_ROWS; i++) draw_nxt[i] = '0;
            end
            CMD_FILL: begin
              for (int i = 0; i < LMFE_ROWS; i++) draw_nxt[i] = '1;
            end
            CMD_LEFT: begin
              for (int i = 0; i < LMFE_ROWS; i++) draw_nxt[i] = draw_r[i] >> 1;
            end
            CMD_RIGHT: begin
              for (int i = 0; i < LMFE_ROWS; i++) draw_nxt[i] = draw_r[i] << 1;
            end
            CMD_UP: begin
              for (int i = 0; i < LMFE_ROWS - 1; i++) draw_nxt[i] = draw_r[i+1];
              draw_nxt[LMFE_ROWS-1] = '0;
            end
            CMD_DOWN: begin
              for (int i = 1; i < LMFE_ROWS; i++) draw_nxt[i] = draw_r[i-1];
              draw_nxt[0] = '0;
            end
            CMD_LINE: begin
              // result comes out of the walker once the last pixel is plotted
              load_out  = 1'b0;
              state_nxt = ST_LINE;
              lx_nxt    = q_cmd.x_first;
              ly_nxt    = q_cmd.y_first;
              acc_nxt   = q_cmd.acc0;
              den_nxt   = q_cmd.den;
              add_nxt   = q_cmd.add;
              cnt_nxt   = q_cmd.den;
              xmaj_nxt  = q_cmd.x_major;
              xneg_nxt  = q_cmd.x_neg;
              yneg_nxt  = q_cmd.y_neg;
              color_nxt = q_cmd.color;
            end
            CMD_FLIP: begin
              shown_nxt = draw_r;
            end
            CMD_TICK: begin
              phase_nxt      = phase_r + 1'b1;
              tick_nxt       = tick_r + 1'b1;
              res.tick_count = tick_nxt;
              res.scan_row   = phase_nxt;
              res.anode_bits = {shown_r[{1'b1, phase_nxt}], shown_r[{1'b0, phase_nxt}]};
            end
            default: begin
            end
          endcase
        end
      end
      ST_LINE: begin
        // last pixel waits for room in the result register
        if ((cnt_r != '0) || out_free) begin
          draw_nxt[ly_r][lx_r] = color_r;
          acc_nxt = carry ? LMFE_COORD_W'(sum - {1'b0, den_r}) : sum[LMFE_COORD_W-1:0];
          if (x_step) lx_nxt = xneg_r ? lx_r - 1'b1 : lx_r + 1'b1;
          if (y_step) ly_nxt = yneg_r ? ly_r - 1'b1 : ly_r + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == '0) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !out_tready);
    out_res_nxt   = load_out ? res : out_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      draw_r      <= '{default: '0};
      shown_r     <= '{default: '0};
      phase_r     <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      draw_r      <= draw_nxt;
      shown_r     <= shown_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lx_r      <= lx_nxt;
    ly_r      <= ly_nxt;
    acc_r     <= acc_nxt;
    den_r     <= den_nxt;
    add_r     <= add_nxt;
    cnt_r     <= cnt_nxt;
    xmaj_r    <= xmaj_nxt;
    xneg_r    <= xneg_nxt;
    yneg_r    <= yneg_nxt;
    color_r   <= color_nxt;
    out_res_r <= out_res_nxt;
  end

  // error term stays below the major-axis length while walking
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINE) |-> ((acc_r < den_r) || (den_r == '0)))
    else $error("line error term out of range");

  // final pixel with room in the result register ends the walk with a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINE && cnt_r == '0 && out_free) |=>
      (state_r == ST_IDLE && out_valid_r))
    else $error("line walk did not finish with a result");

  // a tick advances the scan phase by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_cmd.op == CMD_TICK) |=>
      (phase_r == $past(phase_r) + 3'd1))
    else $error("scan phase did not advance on tick");

  // scan phase and tick counter only change while a command is executing
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !(q_valid && out_free)) |=>
      (tick_r == $past(tick_r) && phase_r == $past(phase_r)))
    else $error("scan state changed without a command");

endmodule

`default_nettype wire

/* rtl/core/led_matrix_framebuffer_engine.sv */
// top level of the 16x16 led matrix framebuffer engine
// instantiates lmfe_front, lmfe_queue and lmfe_back; uses lmfe_pkg
`default_nettype none

// Accepts one command word per handshake and returns exactly one result word per
// command, in order. A word is registered and decoded in the front end (line
// deltas, step directions and major axis worked out there), then waits in a
// short queue for the back end, which holds both 16x16 buffers in flip-flops.
// Plot, read, clear, fill, shifts, flip, tick and unused codes finish as the
// back end takes them; a line starts the walker, which plots max(|dx|,|dy|) + 1
// pixels at one pixel per cycle, the last waiting for room in the result
// register. The back end takes the next command once that register is free or
// being read; a word passes the front-end register, the queue and the result
// register. Both buffers, scan phase and tick counter clear on reset at once.
module led_matrix_framebuffer_engine #(
  parameter int QUEUE_DEPTH = lmfe_pkg::LMFE_QUEUE_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // cmd[3:0], x_first[7:4], y_first[11:8], x_second[15:12], y_second[19:16],
  // color[20], zero fill above
  input  wire logic [lmfe_pkg::LMFE_IN_TDATA_W-1:0]  in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // pixel_on[0], scan_row[3:1], anode_bits[35:4], tick_count[51:36],
  // zero fill above
  output logic [lmfe_pkg::LMFE_OUT_TDATA_W-1:0]      out_tdata
);
  import lmfe_pkg::*;

  logic      push_valid, push_ready, q_valid, q_ready;
  lmfe_cmd_t push_cmd, q_cmd;
  lmfe_res_t out_res;

  lmfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lmfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  lmfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {(LMFE_OUT_TDATA_W - $bits(lmfe_res_t))'(0), out_res};

endmodule

`default_nettype wire

/* verif/lmfe_scoreboard.sv */
`timescale 1ns / 1ps
// scoreboard for the led matrix framebuffer engine: watches both stream ports,
// keeps its own drawing and refresh buffers and checks every result word
// depends on lmfe_pkg for command codes and the result word layout
module lmfe_scoreboard (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [lmfe_pkg::LMFE_IN_TDATA_W-1:0]  in_tdata,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [lmfe_pkg::LMFE_OUT_TDATA_W-1:0] out_tdata,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   cmds_taken,
  output int                                   results_taken,
  output int                                   lines_seen,
  output int                                   reads_seen,
  output int                                   ticks_seen
);
  import lmfe_pkg::*;

  localparam int PRINT_CAP = 50;

  row_t                   draw_img  [LMFE_ROWS];
  row_t                   shown_img [LMFE_ROWS];
  logic [LMFE_PHASE_W-1:0] phase;
  logic [LMFE_TICK_W-1:0]  ticks;
  lmfe_res_t              frame_results_q [$];
  int                     err_count;

  assign mismatches = err_count;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  task automatic set_pixel(input int x, input int y, input logic color);
    draw_img[y & 15][x & 15] = color;
  endtask

  // bresenham walk along the major axis, both endpoints plotted
  task automatic draw_segment(input int xa, input int ya, input int xb, input int yb,
                              input logic color);
    int  dx, dy, sx, sy, den, add, acc, px, py;
    bit  x_major;
    dx = (xb >= xa) ? xb - xa : xa - xb;
    dy = (yb >= ya) ? yb - ya : ya - yb;
    sx = (xb >= xa) ? 1 : -1;
    sy = (yb >= ya) ? 1 : -1;
    x_major = (dx >= dy);
    den = x_major ? dx : dy;
    add = x_major ? dy : dx;
    acc = den / 2;
    px = xa;
    py = ya;
    for (int i = 0; i <= den; i++) begin
      set_pixel(px, py, color);
      acc += add;
      if (acc >= den) begin
        acc -= den;
        if (x_major) py += sy;
        else px += sx;
      end
      if (x_major) px += sx;
      else py += sy;
    end
  endtask

  task automatic predict_frame_result(input logic [LMFE_IN_TDATA_W-1:0] word,
                                      output lmfe_res_t res);
    logic [LMFE_CMD_W-1:0] op;
    coord_t xf, yf, xs, ys;
    logic   color;
    int     lit;
    op    = word[3:0];
    xf    = word[7:4];
    yf    = word[11:8];
    xs    = word[15:12];
    ys    = word[19:16];
    color = word[20];
    res   = '0;
    case (op)
      CMD_PLOT: set_pixel(xf, yf, color);
      CMD_READ: begin
        res.pixel_on = draw_img[yf][xf];
        reads_seen++;
      end
      CMD_CLEAR: for (int r = 0; r < LMFE_ROWS; r++) draw_img[r] = '0;
      CMD_FILL:  for (int r = 0; r < LMFE_ROWS; r++) draw_img[r] = '1;
      CMD_LEFT:  for (int r = 0; r < LMFE_ROWS; r++) draw_img[r] = draw_img[r] >> 1;
      CMD_RIGHT: for (int r = 0; r < LMFE_ROWS; r++) draw_img[r] = draw_img[r] << 1;
      CMD_UP: begin
        for (int r = 0; r < LMFE_ROWS - 1; r++) draw_img[r] = draw_img[r + 1];
        draw_img[LMFE_ROWS - 1] = '0;
      end
      CMD_DOWN: begin
        for (int r = LMFE_ROWS - 1; r > 0; r--) draw_img[r] = draw_img[r - 1];
        draw_img[0] = '0;
      end
      CMD_LINE: begin
        draw_segment(xf, yf, xs, ys, color);
        lines_seen++;
      end
      CMD_FLIP: for (int r = 0; r < LMFE_ROWS; r++) shown_img[r] = draw_img[r];
      CMD_TICK: begin
        ticks = ticks + 1'b1;
        phase = phase + 1'b1;
        lit   = phase;
        res.scan_row   = phase;
        res.anode_bits = {shown_img[lit + 8], shown_img[lit]};
        ticks_seen++;
      end
      default: ;
    endcase
    res.tick_count = ticks;
  endtask

  always @(posedge clk) begin
    lmfe_res_t want, got;
    if (!rst_n) begin
      for (int r = 0; r < LMFE_ROWS; r++) begin
        draw_img[r]  = '0;
        shown_img[r] = '0;
      end
      phase = '0;
      ticks = '0;
      frame_results_q.delete();
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_frame_result(in_tdata, want);
        frame_results_q.push_back(want);
        cmds_taken++;
      end
      if (out_tvalid && out_tready) begin
        results_taken++;
        got = lmfe_res_t'(out_tdata[51:0]);
        if (frame_results_q.size() == 0) begin
          report_mismatch("result word with nothing pending", out_tdata[31:0], '0);
        end else begin
          want = frame_results_q.pop_front();
          if (got.pixel_on != want.pixel_on)
            report_mismatch("pixel_on", got.pixel_on, want.pixel_on);
          if (got.scan_row != want.scan_row)
            report_mismatch("scan_row", got.scan_row, want.scan_row);
          if (got.anode_bits != want.anode_bits)
            report_mismatch("anode_bits", got.anode_bits, want.anode_bits);
          if (got.tick_count != want.tick_count)
            report_mismatch("tick_count", got.tick_count, want.tick_count);
          if (out_tdata[LMFE_OUT_TDATA_W-1:52] != '0)
            report_mismatch("zero fill", out_tdata[LMFE_OUT_TDATA_W-1:52], '0);
        end
      end
      pending <= frame_results_q.size();
    end
  end

endmodule

/* verif/led_matrix_framebuffer_engine_tb.sv */
`timescale 1ns / 1ps
// testbench top for the led matrix framebuffer engine: drives command words,
// stalls the result port at random and gives the verdict
// depends on lmfe_pkg, the engine rtl and lmfe_scoreboard
module led_matrix_framebuffer_engine_tb;
  import lmfe_pkg::*;

  localparam logic [LMFE_CMD_W-1:0] CMD_SPARE_LO = 4'd11;
  localparam logic [LMFE_CMD_W-1:0] CMD_SPARE_HI = 4'd15;
  localparam int RANDOM_WORDS = 368;
  localparam int CALM_WORDS   = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 40;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [LMFE_IN_TDATA_W-1:0]  in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [LMFE_OUT_TDATA_W-1:0] out_tdata;

  bit gaps_on;
  int quiet_cycles;
  int mismatches, pending, cmds_taken, results_taken;
  int lines_seen, reads_seen, ticks_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  led_matrix_framebuffer_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lmfe_scoreboard u_scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .mismatches    (mismatches),
    .pending       (pending),
    .cmds_taken    (cmds_taken),
    .results_taken (results_taken),
    .lines_seen    (lines_seen),
    .reads_seen    (reads_seen),
    .ticks_seen    (ticks_seen)
  );

  task automatic push_cmd(input logic [LMFE_CMD_W-1:0] op, input coord_t xf,
                          input coord_t yf, input coord_t xs, input coord_t ys,
                          input logic color);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, color, ys, xs, yf, xf, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_random_cmd();
    int pick;
    logic [LMFE_CMD_W-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 22)      op = CMD_PLOT;
    else if (pick < 40) op = CMD_READ;
    else if (pick < 55) op = CMD_LINE;
    else if (pick < 67) op = CMD_TICK;
    else if (pick < 73) op = CMD_FLIP;
    else if (pick < 85) op = CMD_LEFT + 4'($urandom_range(0, 3));
    else if (pick < 87) op = CMD_CLEAR;
    else if (pick < 89) op = CMD_FILL;
    else if (pick < 95) op = CMD_SPARE_LO + 4'($urandom_range(0, 4));
    else                op = CMD_LINE;
    push_cmd(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
             1'($urandom_range(0, 1)));
  endtask

  // result side: random stall bursts while gaps are on
  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d results pending",
               STALL_LIMIT, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: blank state, edges, every command, line shapes, unused codes
    push_cmd(CMD_READ,  0,  0,  0,  0, 1'b0);
    push_cmd(CMD_TICK,  15, 15, 15, 15, 1'b1);
    push_cmd(CMD_FILL,  0,  0,  0,  0, 1'b0);
    push_cmd(CMD_READ,  15, 15, 0,  0, 1'b0);
    push_cmd(CMD_PLOT,  15, 15, 0,  0, 1'b0);
    push_cmd(CMD_READ,  15, 15, 15, 15, 1'b1);
    push_cmd(CMD_LEFT,  0,  0,  0,  0, 1'b0);
    push_cmd(CMD_RIGHT, 0,  0,  0,  0, 1'b0);
    push_cmd(CMD_UP,    0,  0,  0,  0, 1'b0);
    push_cmd(CMD_DOWN,  0,  0,  0,  0, 1'b0);
    push_cmd(CMD_FLIP,  0,  0,  0,  0, 1'b0);
    push_cmd(CMD_CLEAR, 0,  0,  0,  0, 1'b0);
    push_cmd(CMD_LINE,  0,  0,  15, 15, 1'b1);
    push_cmd(CMD_LINE,  15, 0,  0,  3, 1'b1);
    push_cmd(CMD_LINE,  2,  15, 5,  0, 1'b1);
    push_cmd(CMD_LINE,  7,  7,  7,  7, 1'b1);
    push_cmd(CMD_LINE,  0,  8,  15, 8, 1'b1);
    push_cmd(CMD_LINE,  3,  0,  3,  15, 1'b1);
    push_cmd(CMD_LINE,  15, 15, 0,  0, 1'b0);
    push_cmd(CMD_PLOT,  0,  0,  0,  0, 1'b1);
    push_cmd(CMD_FLIP,  0,  0,  0,  0, 1'b0);
    push_cmd(CMD_SPARE_LO, 15, 15, 15, 15, 1'b1);
    push_cmd(CMD_SPARE_HI, 0,  0,  0,  0, 1'b0);
    // walk the scan through a full wrap of the phase
    repeat (8) push_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);

    repeat (RANDOM_WORDS - CALM_WORDS) push_random_cmd();
    gaps_on = 1'b0;
    repeat (CALM_WORDS) push_random_cmd();

    push_cmd(CMD_READ, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 0, 0, 1'b0);
    in_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("run took %0d command words and checked %0d result words", cmds_taken,
             results_taken);
    $display("it drew %0d lines, read %0d pixels and made %0d refresh ticks", lines_seen,
             reads_seen, ticks_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
